/* sv/lenc_pkg.sv */
// Shared types, constants and pixel transform functions for the line stream encoder.
`timescale 1ns / 1ps

package lenc_pkg;

    typedef logic [2:0] t_stage;
    typedef logic [1:0] t_sect;
    typedef logic [1:0] t_reg_idx;

    // Drive stages carried with each pull
    localparam t_stage STAGE_COMPENSATE = 3'd0;
    localparam t_stage STAGE_WHITE      = 3'd1;
    localparam t_stage STAGE_INVERSE    = 3'd2;
    localparam t_stage STAGE_NORMAL     = 3'd3;
    localparam t_stage STAGE_POWER_OFF  = 3'd4;

    // Stream sections
    localparam t_sect SECT_ODD  = 2'd0;
    localparam t_sect SECT_SCAN = 2'd1;
    localparam t_sect SECT_EVEN = 2'd2;
    localparam t_sect SECT_NONE = 2'd3;

    // Configuration register indexes
    localparam t_reg_idx REG_LINE_BYTES   = 2'd0;
    localparam t_reg_idx REG_SCAN_BYTES   = 2'd1;
    localparam t_reg_idx REG_FILLER_BYTES = 2'd2;

    localparam logic [6:0] SCAN_LIMIT   = 7'd64;
    localparam logic [7:0] ODD_MASK     = 8'haa;
    localparam logic [7:0] EVEN_MASK    = 8'h55;
    localparam logic [7:0] SCAN_PAIR    = 8'hc0;
    localparam logic [7:0] POWER_OFF_BYTE = 8'h55;

    // Per-transaction information passed from the position stage to the output stage
    typedef struct packed {
        t_sect      sect;
        t_stage     stage;
        logic       dummy;
        logic [7:0] scan;
        logic       last;
    } t_slot;

    function automatic logic [7:0] pair_reverse(input logic [7:0] v);
        pair_reverse = {v[1:0], v[3:2], v[5:4], v[7:6]};
    endfunction

    function automatic logic [7:0] odd_code(input logic [7:0] b, input t_stage stage);
        logic [7:0] o;
        o = b & ODD_MASK;
        unique case (stage)
            STAGE_COMPENSATE: odd_code = ~(o >> 1);
            STAGE_WHITE:      odd_code = o ^ ODD_MASK;
            STAGE_INVERSE:    odd_code = ~o;
            STAGE_NORMAL:     odd_code = (o >> 1) | ODD_MASK;
            STAGE_POWER_OFF:  odd_code = POWER_OFF_BYTE;
            default:          odd_code = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] even_code(input logic [7:0] b, input t_stage stage);
        logic [7:0] e;
        e = b & EVEN_MASK;
        unique case (stage)
            STAGE_COMPENSATE: even_code = pair_reverse(~e);
            STAGE_WHITE:      even_code = pair_reverse((e ^ EVEN_MASK) << 1);
            STAGE_INVERSE:    even_code = pair_reverse((e + EVEN_MASK) ^ ODD_MASK);
            STAGE_NORMAL:     even_code = pair_reverse(e | ODD_MASK);
            STAGE_POWER_OFF:  even_code = POWER_OFF_BYTE;
            default:          even_code = 8'h00;
        endcase
    endfunction

endpackage

/* sv/lenc_buf.sv */
// Line buffer memory: one write port for loads, one registered read port for pulls.
`timescale 1ns / 1ps

module lenc_buf #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data only moves on a pull so that it holds while the pipeline stalls
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/lenc_pos.sv */
// Stream position counter and section decode for each pull.
`timescale 1ns / 1ps

module lenc_pos #(
    parameter int MAX_LINE_BYTES = 64,
    parameter int ADDR_W         = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_pull,
    input  logic [6:0]        i_line_bytes,
    input  logic [6:0]        i_scan_bytes,
    input  logic              i_filler_bytes,
    input  lenc_pkg::t_stage  i_stage,
    input  logic [7:0]        i_line_index,
    input  logic              i_dummy_line,
    output logic [ADDR_W-1:0] o_raddr,
    output lenc_pkg::t_slot   o_slot
);

    import lenc_pkg::*;

    localparam logic [6:0] LINE_LIMIT = 7'(MAX_LINE_BYTES);

    logic [7:0] r_pos;
    logic [7:0] n_pos;
    t_slot      r_slot;
    t_slot      n_slot;

    logic [8:0] len_l;
    logic [8:0] len_s;
    logic [8:0] end_odd;
    logic [8:0] end_scan;
    logic [8:0] end_even;
    logic [8:0] total;
    logic [8:0] pos9;
    logic [8:0] pos_inc;
    logic [8:0] odd_idx;
    logic [8:0] scan_idx;
    logic [8:0] even_idx;
    logic       last;

    always_comb begin
        len_l    = {2'b00, (i_line_bytes > LINE_LIMIT) ? LINE_LIMIT : i_line_bytes};
        len_s    = {2'b00, (i_scan_bytes > SCAN_LIMIT) ? SCAN_LIMIT : i_scan_bytes};
        end_odd  = len_l;
        end_scan = len_l + len_s;
        end_even = end_scan + len_l;
        total    = end_even + {8'd0, i_filler_bytes};
        pos9     = {1'b0, r_pos};
        pos_inc  = pos9 + 9'd1;
        odd_idx  = len_l - 9'd1 - pos9;
        scan_idx = pos9 - len_l;
        even_idx = pos9 - end_scan;
        // A position left beyond the end by a register change also ends the line
        last     = (pos_inc >= total);
        n_pos    = last ? 8'd0 : pos_inc[7:0];

        n_slot.stage = i_stage;
        n_slot.dummy = i_dummy_line;
        n_slot.last  = last;
        n_slot.scan  = 8'h00;
        if (pos9 < end_odd) begin
            n_slot.sect = SECT_ODD;
        end else if (pos9 < end_scan) begin
            n_slot.sect = SECT_SCAN;
            if (!i_dummy_line && (scan_idx == {3'b000, i_line_index[7:2]})) begin
                n_slot.scan = SCAN_PAIR >> {i_line_index[1:0], 1'b0};
            end
        end else if (pos9 < end_even) begin
            n_slot.sect = SECT_EVEN;
        end else begin
            n_slot.sect = SECT_NONE;
        end

        o_raddr = (pos9 < end_odd) ? odd_idx[ADDR_W-1:0] : even_idx[ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 8'd0;
        end else if (i_pull) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_pull) begin
            r_slot <= n_slot;
        end
    end

    assign o_slot = r_slot;

endmodule

/* sv/lenc_out.sv */
// Pixel transform and output register of the stream.
`timescale 1ns / 1ps

module lenc_out (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic            i_slot_valid,
    input  lenc_pkg::t_slot i_slot,
    input  logic [7:0]      i_rdata,
    output logic            o_valid,
    output logic [7:0]      o_byte,
    output logic            o_last
);

    import lenc_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic [7:0] pix;
    logic [7:0] n_byte;

    always_comb begin
        pix = i_slot.dummy ? 8'h00 : i_rdata;
        unique case (i_slot.sect)
            SECT_ODD:  n_byte = odd_code(pix, i_slot.stage);
            SECT_SCAN: n_byte = i_slot.scan;
            SECT_EVEN: n_byte = even_code(pix, i_slot.stage);
            SECT_NONE: n_byte = 8'h00;
            default:   n_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_take) begin
            r_valid <= i_slot_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && i_slot_valid) begin
            r_byte <= n_byte;
            r_last <= i_slot.last;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule

/* sv/epaper_line_data_encoder.sv */
// Top level of the e-paper line stream encoder: handshake, registers and pipeline.
//
// Usage: the input channel (i_in_valid / o_in_ready) carries one transaction per
// item. A load transaction (i_kind = 0) writes i_frame_byte into the line buffer at
// i_byte_index and produces nothing. A pull transaction (i_kind = 1) produces exactly
// one output transaction (o_out_valid / i_out_ready) holding the next byte of the
// line stream and o_last on its final byte, after which the position wraps to zero.
// The edge that accepts a pull registers its position decode and buffer read into the
// middle stage, and a later edge at which the output register is free or being read
// registers the pixel transform into the output. While o_in_ready is high, one
// transaction is accepted every cycle; the rate is set by the single read port of the
// line buffer, which serves one pull per cycle. Registers are to be written over the
// APB port only while no pull is in flight; the block itself does not enforce this.
// Reset (synchronous, active low) clears the position, the pipeline valid bits and the
// registers to 33 line bytes, 44 scan bytes and one filler byte; the buffer contents
// stay undefined until loaded. When the receiver stalls, the output register holds
// and the middle stage fills, after which o_in_ready falls until the output moves.
`timescale 1ns / 1ps

module epaper_line_data_encoder #(
    parameter int MAX_LINE_BYTES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // APB configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // Input channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_kind,
    input  logic [5:0]          i_byte_index,
    input  logic [7:0]          i_frame_byte,
    input  lenc_pkg::t_stage    i_stage,
    input  logic [7:0]          i_line_index,
    input  logic                i_dummy_line,
    // Output channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [7:0]          o_out_byte,
    output logic                o_last
);

    import lenc_pkg::*;

    localparam int ADDR_W = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
    localparam logic [6:0] DEPTH_7 = 7'(MAX_LINE_BYTES);

    logic [6:0]  r_line_bytes;
    logic [6:0]  r_scan_bytes;
    logic        r_filler_bytes;
    logic        r_s1_valid;

    logic        cfg_wr;
    t_reg_idx    cfg_idx;
    logic        in_accept;
    logic        pull;
    logic        load_we;
    logic        out_take;
    logic [ADDR_W-1:0] raddr;
    logic [7:0]  rdata;
    t_slot       slot;

    assign cfg_idx   = paddr[3:2];
    assign cfg_wr    = psel && penable && pwrite;
    assign pready    = 1'b1;

    assign out_take  = !o_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || out_take;
    assign in_accept = i_in_valid && o_in_ready;
    assign pull      = in_accept && i_kind;
    assign load_we   = in_accept && !i_kind && ({1'b0, i_byte_index} < DEPTH_7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_bytes   <= 7'd33;
            r_scan_bytes   <= 7'd44;
            r_filler_bytes <= 1'b1;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_LINE_BYTES:   r_line_bytes   <= pwdata[6:0];
                REG_SCAN_BYTES:   r_scan_bytes   <= pwdata[6:0];
                REG_FILLER_BYTES: r_filler_bytes <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_LINE_BYTES:   prdata = {25'd0, r_line_bytes};
            REG_SCAN_BYTES:   prdata = {25'd0, r_scan_bytes};
            REG_FILLER_BYTES: prdata = {31'd0, r_filler_bytes};
            default:          prdata = 32'd0;
        endcase
    end

    // The middle stage holds pulls only; loads finish at the buffer write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= pull;
        end
    end

    lenc_pos #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .ADDR_W         (ADDR_W)
    ) u_pos (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (o_in_ready),
        .i_pull         (pull),
        .i_line_bytes   (r_line_bytes),
        .i_scan_bytes   (r_scan_bytes),
        .i_filler_bytes (r_filler_bytes),
        .i_stage        (i_stage),
        .i_line_index   (i_line_index),
        .i_dummy_line   (i_dummy_line),
        .o_raddr        (raddr),
        .o_slot         (slot)
    );

    lenc_buf #(
        .DEPTH  (MAX_LINE_BYTES),
        .ADDR_W (ADDR_W)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (i_byte_index[ADDR_W-1:0]),
        .i_wdata (i_frame_byte),
        .i_re    (pull),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    lenc_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (out_take),
        .i_slot_valid (r_s1_valid),
        .i_slot       (slot),
        .i_rdata      (rdata),
        .o_valid      (o_out_valid),
        .o_byte       (o_out_byte),
        .o_last       (o_last)
    );

    // Input back-pressure only arises from a stalled, occupied output register
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without an output stall");

    // A pull occupies the middle stage in the next cycle
    a_pull_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_kind) |=> r_s1_valid)
        else $error("accepted pull lost before the middle stage");

    // A load never creates a pipeline entry
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_kind) |=> !r_s1_valid)
        else $error("load transaction entered the result pipeline");

    // A waiting middle-stage entry moves to the output as soon as it can
    a_s1_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && (!o_out_valid || i_out_ready)) |=> o_out_valid)
        else $error("middle stage entry not transferred to the output");

endmodule

/* bench/line_stream_checker.sv */
// Item kind codes shared by the bench, and the checker that predicts and compares line stream bytes.
`timescale 1ns / 1ps

package line_stream_tb_pkg;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_PULL = 1'b1;

endpackage

module line_stream_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    input  logic [31:0]      prdata,
    input  logic             pready,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic             i_kind,
    input  logic [5:0]       i_byte_index,
    input  logic [7:0]       i_frame_byte,
    input  lenc_pkg::t_stage i_stage,
    input  logic [7:0]       i_line_index,
    input  logic             i_dummy_line,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [7:0]       i_out_byte,
    input  logic             i_last,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_byte_count,
    output int               o_last_count
);

    import lenc_pkg::*;
    import line_stream_tb_pkg::*;

    localparam int LINE_MAX = 64;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_line_byte;

    logic [7:0] frame_line [LINE_MAX];
    logic [6:0] line_bytes;
    logic [6:0] scan_bytes;
    logic       filler_bytes;
    int         stream_pos;
    t_line_byte line_bytes_due [$];

    task automatic report_mismatch(input string what);
        if (o_fail_count < 40) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        o_fail_count++;
    endtask

    function automatic logic [7:0] swap_pairs(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 4; k++) begin
            r[2*k +: 2] = v[6-2*k +: 2];
        end
        return r;
    endfunction

    function automatic logic [7:0] odd_section_byte(input logic [7:0] px, input t_stage st);
        logic [7:0] o;
        o = px & ODD_MASK;
        case (st)
            STAGE_COMPENSATE: return ~(o >> 1);
            STAGE_WHITE:      return o ^ 8'haa;
            STAGE_INVERSE:    return ~o;
            STAGE_NORMAL:     return (o >> 1) | 8'haa;
            STAGE_POWER_OFF:  return 8'h55;
            default:          return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] even_section_byte(input logic [7:0] px, input t_stage st);
        logic [7:0] e;
        logic [7:0] w;
        e = px & EVEN_MASK;
        case (st)
            STAGE_COMPENSATE: w = ~e;
            STAGE_WHITE:      w = (e ^ 8'h55) << 1;
            STAGE_INVERSE:    w = (e + 8'h55) ^ 8'haa;
            STAGE_NORMAL:     w = e | 8'haa;
            STAGE_POWER_OFF:  return 8'h55;
            default:          return 8'h00;
        endcase
        return swap_pairs(w);
    endfunction

    // Works out the byte at the current stream position and moves the position on.
    function automatic t_line_byte next_stream_byte(input t_stage st, input logic [7:0] line,
                                                    input logic dmy);
        int         lb;
        int         sb;
        int         total;
        int         p;
        logic [7:0] px;
        t_line_byte r;
        lb = (line_bytes > LINE_MAX) ? LINE_MAX : int'(line_bytes);
        sb = (scan_bytes > SCAN_LIMIT) ? int'(SCAN_LIMIT) : int'(scan_bytes);
        total = lb + sb + lb + int'(filler_bytes);
        p = stream_pos;
        r.data = 8'h00;
        if (p < lb) begin
            px = dmy ? 8'h00 : frame_line[lb - 1 - p];
            r.data = odd_section_byte(px, st);
        end else if (p < lb + sb) begin
            if (!dmy && (p - lb) == int'(line[7:2])) begin
                r.data = SCAN_PAIR >> {line[1:0], 1'b0};
            end
        end else if (p < lb + sb + lb) begin
            px = dmy ? 8'h00 : frame_line[p - lb - sb];
            r.data = even_section_byte(px, st);
        end
        r.last = (p + 1 >= total);
        stream_pos = r.last ? 0 : p + 1;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_line_byte want;
        logic [31:0] reg_value;
        if (!i_rst_n) begin
            line_bytes = 7'd33;
            scan_bytes = 7'd44;
            filler_bytes = 1'b1;
            stream_pos = 0;
            line_bytes_due.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (t_reg_idx'(paddr[3:2]))
                        REG_LINE_BYTES:   line_bytes = pwdata[6:0];
                        REG_SCAN_BYTES:   scan_bytes = pwdata[6:0];
                        REG_FILLER_BYTES: filler_bytes = pwdata[0];
                        default: ;
                    endcase
                end else begin
                    case (t_reg_idx'(paddr[3:2]))
                        REG_LINE_BYTES:   reg_value = {25'd0, line_bytes};
                        REG_SCAN_BYTES:   reg_value = {25'd0, scan_bytes};
                        REG_FILLER_BYTES: reg_value = {31'd0, filler_bytes};
                        default:          reg_value = prdata;
                    endcase
                    if (prdata !== reg_value) begin
                        report_mismatch($sformatf("register at %0d read %0h, expected %0h",
                                                  paddr, prdata, reg_value));
                    end
                end
            end
            // Outputs are compared before this edge's input is taken, since a pull
            // accepted now cannot already have its byte on the output.
            if (i_out_valid && i_out_ready) begin
                o_byte_count++;
                if (i_last === 1'b1) begin
                    o_last_count++;
                end
                if (line_bytes_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected stream byte %02h last %b",
                                              i_out_byte, i_last));
                end else begin
                    want = line_bytes_due.pop_front();
                    if (i_out_byte !== want.data) begin
                        report_mismatch($sformatf("stream byte %02h, expected %02h",
                                                  i_out_byte, want.data));
                    end
                    if (i_last !== want.last) begin
                        report_mismatch($sformatf("last flag %b, expected %b (byte %02h)",
                                                  i_last, want.last, want.data));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_kind == KIND_LOAD) begin
                    frame_line[i_byte_index] = i_frame_byte;
                end else begin
                    line_bytes_due.push_back(next_stream_byte(i_stage, i_line_index,
                                                              i_dummy_line));
                end
            end
        end
        o_pending = line_bytes_due.size();
    end

endmodule

/* bench/epaper_line_data_encoder_tb.sv */
// Top of the line stream encoder bench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module epaper_line_data_encoder_tb;

    import lenc_pkg::*;
    import line_stream_tb_pkg::*;

    localparam int ITEM_TARGET = 1850;
    localparam int WATCHDOG_LIMIT = 3000;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        in_kind = KIND_LOAD;
    logic [5:0]  in_byte_index = 6'd0;
    logic [7:0]  in_frame_byte = 8'd0;
    t_stage      in_stage = STAGE_COMPENSATE;
    logic [7:0]  in_line_index = 8'd0;
    logic        in_dummy_line = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b1;
    logic [7:0]  out_byte;
    logic        out_last;

    int fail_count;
    int pending;
    int byte_count;
    int last_count;

    int          sent_items = 0;
    int          load_count = 0;
    int          pull_count = 0;
    int          setting_count = 0;
    int          burst_left = 0;
    logic        gap_quiet = 1'b0;
    logic [63:0] loaded = 64'd0;
    logic [6:0]  cur_line_bytes = 7'd33;
    int          quiet_cycles = 0;

    int          rx_cycle = 0;
    int          rx_mode = 0;
    int          rx_run = 0;

    epaper_line_data_encoder dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_kind       (in_kind),
        .i_byte_index (in_byte_index),
        .i_frame_byte (in_frame_byte),
        .i_stage      (in_stage),
        .i_line_index (in_line_index),
        .i_dummy_line (in_dummy_line),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_out_byte   (out_byte),
        .o_last       (out_last)
    );

    line_stream_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_kind       (in_kind),
        .i_byte_index (in_byte_index),
        .i_frame_byte (in_frame_byte),
        .i_stage      (in_stage),
        .i_line_index (in_line_index),
        .i_dummy_line (in_dummy_line),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_byte   (out_byte),
        .i_last       (out_last),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_byte_count (byte_count),
        .o_last_count (last_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver switches at random between always ready, coin-flip
    // stalls and long stalls with short ready windows.
    always @(posedge clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 512 == 0) begin
            rx_mode <= $urandom_range(0, 2);
        end
        if (rx_run != 0) begin
            rx_run <= rx_run - 1;
        end else begin
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                default: begin
                    out_ready <= ~out_ready;
                    rx_run <= out_ready ? $urandom_range(1, 20) : $urandom_range(0, 6);
                end
            endcase
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("[epaper_line_data_encoder] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_item(input logic kind, input logic [5:0] idx, input logic [7:0] fb,
                             input t_stage st, input logic [7:0] line, input logic dmy);
        int gap;
        if (burst_left == 0) begin
            gap = gap_quiet ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_kind <= kind;
        in_byte_index <= idx;
        in_frame_byte <= fb;
        in_stage <= st;
        in_line_index <= line;
        in_dummy_line <= dmy;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_items++;
    endtask

    task automatic load_byte(input logic [5:0] idx, input logic [7:0] value);
        push_item(KIND_LOAD, idx, value, t_stage'($urandom_range(0, 7)), 8'($urandom),
                  1'($urandom));
        loaded[idx] = 1'b1;
        load_count++;
    endtask

    task automatic pull_byte(input t_stage st, input logic [7:0] line, input logic dmy);
        push_item(KIND_PULL, 6'($urandom), 8'($urandom), st, line, dmy);
        pull_count++;
    endtask

    // Waits until every pull has produced its byte and the pipeline has emptied.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(input t_reg_idx idx, input logic [6:0] value);
        logic [31:0] noise;
        noise = $urandom;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= (idx == REG_FILLER_BYTES) ? {noise[31:1], value[0]} : {noise[31:7], value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_LINE_BYTES) begin
            cur_line_bytes = value;
        end
    endtask

    task automatic reg_read(input t_reg_idx idx);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_all();
        reg_read(REG_LINE_BYTES);
        reg_read(REG_SCAN_BYTES);
        reg_read(REG_FILLER_BYTES);
    endtask

    // Every buffer entry that the current line length reads must hold a loaded byte.
    task automatic load_missing_entries();
        int span;
        span = (cur_line_bytes > 64) ? 64 : int'(cur_line_bytes);
        for (int i = 0; i < span; i++) begin
            if (!loaded[i]) begin
                load_byte(6'(i), 8'($urandom));
            end
        end
    endtask

    function automatic logic [6:0] pick_length();
        case ($urandom_range(0, 11))
            0:       return 7'd0;
            1:       return 7'd1;
            2:       return 7'd64;
            3:       return 7'd127;
            4:       return 7'($urandom_range(65, 127));
            5:       return 7'($urandom_range(1, 64));
            default: return 7'($urandom_range(1, 12));
        endcase
    endfunction

    initial begin
        int         phase_len;
        int         run_left;
        int         scan_span;
        int         pick;
        t_stage     run_stage;
        logic [7:0] run_line;
        logic       run_dummy;
        logic [6:0] scan_len;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset values, a seven-byte stream across all stages, a dummy
        // line, an empty stream and a position left past the end.
        read_all();
        reg_write(REG_LINE_BYTES, 7'd2);
        reg_write(REG_SCAN_BYTES, 7'd2);
        reg_write(REG_FILLER_BYTES, 1'b1);
        setting_count++;
        load_byte(6'd0, 8'hff);
        load_byte(6'd1, 8'h00);
        load_byte(6'd63, 8'ha5);
        for (int i = 0; i < 7; i++) begin
            pull_byte(t_stage'(i), 8'd5, 1'b0);
        end
        for (int i = 0; i < 7; i++) begin
            pull_byte(STAGE_NORMAL, 8'd7, 1'b1);
        end
        load_byte(6'd1, 8'h5a);
        for (int i = 0; i < 7; i++) begin
            pull_byte(t_stage'(7 - i), 8'd4, 1'b0);
        end
        pull_byte(STAGE_INVERSE, 8'd255, 1'b0);
        settle();
        reg_write(REG_LINE_BYTES, 7'd0);
        reg_write(REG_SCAN_BYTES, 7'd0);
        reg_write(REG_FILLER_BYTES, 1'b0);
        setting_count++;
        read_all();
        pull_byte(STAGE_WHITE, 8'd0, 1'b0);
        pull_byte(STAGE_POWER_OFF, 8'd0, 1'b0);
        settle();
        reg_write(REG_LINE_BYTES, 7'd2);
        reg_write(REG_SCAN_BYTES, 7'd3);
        setting_count++;
        for (int i = 0; i < 5; i++) begin
            pull_byte(STAGE_COMPENSATE, 8'd9, 1'b0);
        end
        settle();
        reg_write(REG_LINE_BYTES, 7'd1);
        reg_write(REG_SCAN_BYTES, 7'd1);
        setting_count++;
        pull_byte(STAGE_NORMAL, 8'd0, 1'b0);
        pull_byte(STAGE_NORMAL, 8'd0, 1'b0);

        // Random phases: new register settings, then runs of pulls that follow one
        // line through its stream, with loads and odd pulls mixed in.
        scan_len = 7'd1;
        run_left = 0;
        run_stage = STAGE_NORMAL;
        run_line = 8'd0;
        run_dummy = 1'b0;
        while (sent_items < ITEM_TARGET) begin
            settle();
            if ($urandom_range(0, 1)) begin
                reg_write(REG_LINE_BYTES, pick_length());
            end
            if ($urandom_range(0, 1)) begin
                scan_len = pick_length();
                reg_write(REG_SCAN_BYTES, scan_len);
            end
            if ($urandom_range(0, 2) == 0) begin
                reg_write(REG_FILLER_BYTES, 1'($urandom));
            end
            if ($urandom_range(0, 7) == 0) begin
                read_all();
            end
            setting_count++;
            load_missing_entries();
            gap_quiet = ($urandom_range(0, 3) == 0);
            scan_span = (scan_len == 0) ? 1 : ((scan_len > 64) ? 64 : int'(scan_len));
            phase_len = $urandom_range(10, 140);
            for (int n = 0; n < phase_len; n++) begin
                if (run_left == 0) begin
                    run_left = $urandom_range(1, 60);
                    run_stage = ($urandom_range(0, 9) < 8) ? t_stage'($urandom_range(0, 4))
                                                           : t_stage'($urandom_range(5, 7));
                    run_line = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                           : 8'($urandom_range(0,
                                                                 4 * scan_span - 1));
                    run_dummy = ($urandom_range(0, 7) == 0);
                end
                pick = $urandom_range(0, 99);
                if (pick < 12) begin
                    load_byte(6'($urandom), 8'($urandom));
                end else if (pick < 17) begin
                    pull_byte(t_stage'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
                end else begin
                    pull_byte(run_stage, run_line, run_dummy);
                    run_left--;
                end
            end
        end

        settle();
        repeat (8) @(posedge clk);
        $display("Sent %0d transactions (%0d loads, %0d pulls) over %0d register settings.",
                 sent_items, load_count, pull_count, setting_count);
        $display("Checked %0d stream bytes, %0d of them closing a line; %0d mismatches.",
                 byte_count, last_count, fail_count);
        if (fail_count == 0) begin
            $display("[epaper_line_data_encoder] OK");
        end else begin
            $display("[epaper_line_data_encoder] ERROR");
        end
        $finish;
    end

endmodule
